### hw/rtl/cda_pkg.sv
// cda_pkg: shared types, widths and calendar constants for calendar_date_advance
// used by cda_month_len and calendar_date_advance; no dependencies
package cda_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 10;

  localparam logic [YEAR_W-1:0]  YEAR_MAX      = YEAR_W'(9999);
  localparam logic [COUNT_W-1:0] MAX_DAY_COUNT = COUNT_W'(1023);

  // divisibility by 25 through the inverse of 25 modulo 2**YEAR_W
  localparam logic [YEAR_W-1:0] INV25       = YEAR_W'(7209);
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = YEAR_W'(((1 << YEAR_W) - 1) / 25);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0] LEN_28    = DAY_W'(28);
  localparam logic [DAY_W-1:0] LEN_29    = DAY_W'(29);
  localparam logic [DAY_W-1:0] LEN_30    = DAY_W'(30);
  localparam logic [DAY_W-1:0] LEN_31    = DAY_W'(31);

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic               action;
    logic [YEAR_W-1:0]  new_year;
    logic [MONTH_W-1:0] new_month;
    logic [DAY_W-1:0]   new_day;
    logic [COUNT_W-1:0] day_count;
  } in_beat_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               status;
  } out_beat_t;

endpackage

### hw/rtl/cda_month_len.sv
// cda_month_len: leap rule of 4, 100 and 400 and length of a month
// depends on cda_pkg
module cda_month_len (
  input  logic [cda_pkg::YEAR_W-1:0]  year_i,
  input  logic [cda_pkg::MONTH_W-1:0] month_i,
  output logic [cda_pkg::DAY_W-1:0]   len_o
);

  logic [cda_pkg::YEAR_W-1:0] prod;
  logic                       div4;
  logic                       div16;
  logic                       div25;
  logic                       leap;

  assign prod  = cda_pkg::YEAR_W'(year_i * cda_pkg::INV25);
  assign div25 = (prod <= cda_pkg::DIV25_LIMIT);
  assign div4  = (year_i[1:0] == 2'b00);
  assign div16 = (year_i[3:0] == 4'b0000);
  assign leap  = (div4 && !div25) || (div16 && div25);

  always_comb begin
    if (month_i == cda_pkg::MONTH_FEB) begin
      len_o = leap ? cda_pkg::LEN_29 : cda_pkg::LEN_28;
    end else if (month_i == cda_pkg::MONTH_APR || month_i == cda_pkg::MONTH_JUN ||
                 month_i == cda_pkg::MONTH_SEP || month_i == cda_pkg::MONTH_NOV) begin
      len_o = cda_pkg::LEN_30;
    end else begin
      len_o = cda_pkg::LEN_31;
    end
  end

endmodule

### hw/rtl/calendar_date_advance.sv
// calendar_date_advance: stored gregorian date with load check and day-count advance
// a load or a zero-count advance registers its result from ST_LOAD or ST_ADV once the input beat
// is taken; an advance first walks in steps, one per month boundary crossed plus one
// for a partial month, so 1023 days take at most 35 steps
// a new beat is taken only once the result is registered, so the block takes no new beat
// while one is in work; a stalled result holds the block in its last step
// reset sets the date to year 0, january 1 and leaves no result pending
// depends on cda_pkg and cda_month_len
module calendar_date_advance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cda_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cda_pkg::out_beat_t out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADV
  } state_e;

  state_e                      state_q, state_d;
  logic [cda_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [cda_pkg::MONTH_W-1:0] month_q, month_d;
  logic [cda_pkg::DAY_W-1:0]   day_q, day_d;
  logic [cda_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  cda_pkg::in_beat_t           item_q, item_d;
  logic                        out_valid_q, out_valid_d;
  cda_pkg::out_beat_t          out_q, out_d;

  logic [cda_pkg::YEAR_W-1:0]  unit_year;
  logic [cda_pkg::MONTH_W-1:0] unit_month;
  logic [cda_pkg::DAY_W-1:0]   unit_len;
  logic [cda_pkg::DAY_W-1:0]   left;
  logic                        accept;
  logic                        out_free;
  logic                        load_ok;

  assign unit_year  = (state_q == ST_LOAD) ? item_q.new_year  : year_q;
  assign unit_month = (state_q == ST_LOAD) ? item_q.new_month : month_q;

  cda_month_len u_month_len (
    .year_i  (unit_year),
    .month_i (unit_month),
    .len_o   (unit_len)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign left    = (day_q < unit_len) ? (unit_len - day_q) : '0;
  assign load_ok = (item_q.new_year <= cda_pkg::YEAR_MAX) &&
                   (item_q.new_month >= cda_pkg::MONTH_JAN) &&
                   (item_q.new_month <= cda_pkg::MONTH_DEC) &&
                   (item_q.new_day >= cda_pkg::DAY_FIRST) &&
                   (item_q.new_day <= unit_len);

  always_comb begin
    state_d     = state_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          cnt_d  = (in_data_i.day_count > cda_pkg::MAX_DAY_COUNT) ?
                   cda_pkg::MAX_DAY_COUNT : in_data_i.day_count;
          state_d = (in_data_i.action == cda_pkg::ACT_ADVANCE) ? ST_ADV : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (load_ok) begin
            year_d  = item_q.new_year;
            month_d = item_q.new_month;
            day_d   = item_q.new_day;
            out_d   = '{year: item_q.new_year, month: item_q.new_month,
                        day: item_q.new_day, status: cda_pkg::STATUS_DONE};
          end else begin
            out_d   = '{year: year_q, month: month_q, day: day_q,
                        status: cda_pkg::STATUS_INVALID};
          end
        end
      end
      ST_ADV: begin
        if (cnt_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
            out_d       = '{year: year_q, month: month_q, day: day_q,
                            status: cda_pkg::STATUS_DONE};
          end
        end else if (cda_pkg::COUNT_W'(left) >= cnt_q) begin
          day_d = day_q + cnt_q[cda_pkg::DAY_W-1:0];
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q - (cda_pkg::COUNT_W'(left) + cda_pkg::COUNT_W'(1));
          day_d = cda_pkg::DAY_FIRST;
          if (month_q >= cda_pkg::MONTH_DEC) begin
            month_d = cda_pkg::MONTH_JAN;
            year_d  = (year_q >= cda_pkg::YEAR_MAX) ? '0 : year_q + cda_pkg::YEAR_W'(1);
          end else begin
            month_d = month_q + cda_pkg::MONTH_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      year_q      <= '0;
      month_q     <= cda_pkg::MONTH_JAN;
      day_q       <= cda_pkg::DAY_FIRST;
      cnt_q       <= '0;
      item_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      cnt_q       <= cnt_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // stored date stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q >= cda_pkg::MONTH_JAN) && (month_q <= cda_pkg::MONTH_DEC) &&
    (day_q != '0) && (year_q <= cda_pkg::YEAR_MAX))
    else $error("stored date out of range");

  // a taken beat starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOAD || state_q == ST_ADV))
    else $error("beat taken without starting work");

  // every advance step shrinks the remaining count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV && cnt_q != '0) |=> (cnt_q < $past(cnt_q)))
    else $error("advance made no progress");

  // a result only comes out of a working state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) != ST_IDLE))
    else $error("result beat without an item");

endmodule

### dv/cda_tb_pkg.sv
// cda_tb_pkg: date predictor and result scoreboard for the calendar_date_advance testbench
// depends on cda_pkg for the beat types, widths and calendar constants
package cda_tb_pkg;
  import cda_pkg::*;

  class date_scoreboard;
    logic [YEAR_W-1:0]  year_q;
    logic [MONTH_W-1:0] month_q;
    logic [DAY_W-1:0]   day_q;
    out_beat_t          pending_dates[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        loads;
    int unsigned        rejects;
    int unsigned        advances;
    int unsigned        wraps;

    function new();
      year_q   = '0;
      month_q  = MONTH_JAN;
      day_q    = DAY_FIRST;
      errors   = 0;
      checked  = 0;
      loads    = 0;
      rejects  = 0;
      advances = 0;
      wraps    = 0;
    endfunction

    function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned month_days(int unsigned y, int unsigned m);
      if (m == MONTH_FEB) return is_leap(y) ? LEN_29 : LEN_28;
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return LEN_30;
      return LEN_31;
    endfunction

    function bit date_valid(int unsigned y, int unsigned m, int unsigned d);
      if (y > YEAR_MAX) return 1'b0;
      if (m < MONTH_JAN || m > MONTH_DEC) return 1'b0;
      if (d < DAY_FIRST || d > month_days(y, m)) return 1'b0;
      return 1'b1;
    endfunction

    function out_beat_t next_date(in_beat_t b);
      out_beat_t   r;
      int unsigned y, m, d, n, len, left;
      y = year_q;
      m = month_q;
      d = day_q;
      r.status = STATUS_DONE;
      if (b.action == ACT_LOAD) begin
        loads++;
        if (date_valid(b.new_year, b.new_month, b.new_day)) begin
          y = b.new_year;
          m = b.new_month;
          d = b.new_day;
        end else begin
          r.status = STATUS_INVALID;
          rejects++;
        end
      end else begin
        advances++;
        n = (b.day_count > MAX_DAY_COUNT) ? MAX_DAY_COUNT : b.day_count;
        while (n > 0) begin
          len  = month_days(y, m);
          left = (d < len) ? len - d : 0;
          if (n <= left) begin
            d = d + n;
            n = 0;
          end else begin
            n = n - (left + 1);
            d = DAY_FIRST;
            if (m >= MONTH_DEC) begin
              m = MONTH_JAN;
              if (y >= YEAR_MAX) begin
                y = 0;
                wraps++;
              end else begin
                y = y + 1;
              end
            end else begin
              m = m + 1;
            end
          end
        end
      end
      year_q  = YEAR_W'(y);
      month_q = MONTH_W'(m);
      day_q   = DAY_W'(d);
      r.year  = year_q;
      r.month = month_q;
      r.day   = day_q;
      return r;
    endfunction

    function void note_beat(in_beat_t b);
      pending_dates.push_back(next_date(b));
    endfunction

    function int unsigned pending();
      return pending_dates.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result %0d-%0d-%0d status %0b with nothing pending",
                                  got.year, got.month, got.day, got.status));
        return;
      end
      want = pending_dates.pop_front();
      checked++;
      if (got.year !== want.year)
        report_mismatch($sformatf("year %0d, want %0d", got.year, want.year));
      if (got.month !== want.month)
        report_mismatch($sformatf("month %0d, want %0d", got.month, want.month));
      if (got.day !== want.day)
        report_mismatch($sformatf("day %0d, want %0d", got.day, want.day));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
    endtask
  endclass

endpackage

### dv/tb_calendar_date_advance.sv
// tb_calendar_date_advance: drives load and advance beats into calendar_date_advance and
// checks every result beat against the date scoreboard; depends on cda_pkg and cda_tb_pkg
module tb_calendar_date_advance;
  timeunit 1ns;
  timeprecision 1ps;
  import cda_pkg::*;
  import cda_tb_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 40;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid;
  logic           in_stall;
  in_beat_t       in_data;
  logic           out_valid;
  logic           out_stall;
  out_beat_t      out_data;
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  date_scoreboard sb = new();

  calendar_date_advance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic in_beat_t make_beat(logic act, int unsigned y, int unsigned m,
                                         int unsigned d, int unsigned c);
    in_beat_t b;
    b.action    = act;
    b.new_year  = YEAR_W'(y);
    b.new_month = MONTH_W'(m);
    b.new_day   = DAY_W'(d);
    b.day_count = COUNT_W'(c);
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    int unsigned sel, y, m, d, c, len;
    sel = $urandom_range(99);
    y   = $urandom_range(9999);
    m   = $urandom_range(MONTH_JAN, MONTH_DEC);
    c   = $urandom_range(1023);
    if (sel < 45) begin
      case ($urandom_range(9))
        0: y = $urandom_range(9990, 9999);
        1: y = 100 * $urandom_range(99);
        default: ;
      endcase
      len = sb.month_days(y, m);
      d   = ($urandom_range(9) < 3) ? len : $urandom_range(1, len);
      return make_beat(ACT_LOAD, y, m, d, c);
    end
    if (sel < 85) begin
      case ($urandom_range(4))
        0, 1: c = $urandom_range(40);
        2: c = ($urandom_range(1)) ? 1023 : 0;
        default: ;
      endcase
      return make_beat(ACT_ADVANCE, $urandom_range(16383), $urandom_range(15),
                       $urandom_range(31), c);
    end
    if ($urandom_range(1))
      return make_beat(ACT_LOAD, $urandom_range(16383), $urandom_range(15),
                       $urandom_range(31), c);
    return make_beat(ACT_LOAD, y, m, sb.month_days(y, m) + 1, c);
  endfunction

  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_beat(b);
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_beat(random_beat());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) sb.check_beat(out_data);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #20ms;
    $display("tb_calendar_date_advance failed");
    $finish;
  end

  initial begin
    in_beat_t directed[$];
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    // reset date, leap and century rules, month ends, bad fields, year wrap
    directed.push_back(make_beat(ACT_ADVANCE, 0, 0, 0, 0));
    directed.push_back(make_beat(ACT_ADVANCE, 16383, 15, 31, 1023));
    directed.push_back(make_beat(ACT_LOAD, 2000, 2, 29, 0));
    directed.push_back(make_beat(ACT_LOAD, 1900, 2, 29, 0));
    directed.push_back(make_beat(ACT_LOAD, 2023, 2, 29, 0));
    directed.push_back(make_beat(ACT_LOAD, 2024, 2, 29, 0));
    directed.push_back(make_beat(ACT_ADVANCE, 0, 0, 0, 1));
    directed.push_back(make_beat(ACT_LOAD, 2023, 4, 31, 0));
    directed.push_back(make_beat(ACT_LOAD, 2023, 4, 30, 1023));
    directed.push_back(make_beat(ACT_ADVANCE, 0, 0, 0, 1));
    directed.push_back(make_beat(ACT_LOAD, 2023, 1, 31, 0));
    directed.push_back(make_beat(ACT_ADVANCE, 0, 0, 0, 1));
    directed.push_back(make_beat(ACT_LOAD, 2023, 0, 10, 0));
    directed.push_back(make_beat(ACT_LOAD, 2023, 13, 10, 0));
    directed.push_back(make_beat(ACT_LOAD, 2023, 15, 31, 0));
    directed.push_back(make_beat(ACT_LOAD, 2023, 6, 0, 0));
    directed.push_back(make_beat(ACT_LOAD, 10000, 1, 1, 0));
    directed.push_back(make_beat(ACT_LOAD, 16383, 12, 31, 1023));
    directed.push_back(make_beat(ACT_LOAD, 9999, 12, 31, 0));
    directed.push_back(make_beat(ACT_ADVANCE, 0, 0, 0, 1));
    directed.push_back(make_beat(ACT_LOAD, 9999, 12, 1, 0));
    directed.push_back(make_beat(ACT_ADVANCE, 0, 0, 0, 1023));
    directed.push_back(make_beat(ACT_ADVANCE, 16383, 15, 31, 0));
    directed.push_back(make_beat(ACT_LOAD, 0, 2, 29, 1023));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct  = 10;
    stall_pct = 76;
    foreach (directed[i]) send_beat(directed[i]);
    run_random(330);
    wait_drained();

    idle_pct  = 76;
    stall_pct = 10;
    run_random(350);
    wait_drained();

    idle_pct  = 0;
    stall_pct = 0;
    run_random(350);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d loads (%0d rejected) and %0d advances with %0d year wraps",
             sb.loads, sb.rejects, sb.advances, sb.wraps);
    $display("%0d result beats checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_calendar_date_advance passed");
    end else begin
      $display("tb_calendar_date_advance failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cda_pkg.sv
hw/rtl/cda_month_len.sv
hw/rtl/calendar_date_advance.sv
dv/cda_tb_pkg.sv
dv/tb_calendar_date_advance.sv
